### rtl/core/sfiq_pkg.sv
// ----------------------------------------------------------------------------
// sfiq_pkg
// Shared defaults, register map and controller/datapath handshake types for
// the symmetric I/Q FIR filter.
// ----------------------------------------------------------------------------
package sfiq_pkg;

  localparam int TAPS_DEF         = 65;
  localparam int COEF_SETS_DEF    = 2;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 16;

  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_PROFILE = 3'd0;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  typedef struct packed {
    logic push;     // accept sample item: write delay line, clear accumulator
    logic coef_wr;  // accept coefficient item
    logic issue;    // read one tap pair
    logic center;   // current read is the centre tap
    logic finish;   // round, saturate and load output register
  } sfiq_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } sfiq_stat_t;

endpackage

### rtl/core/sfiq_in_if.sv
// ----------------------------------------------------------------------------
// sfiq_in_if
// Input item channel: sample or coefficient write.
// ----------------------------------------------------------------------------
interface sfiq_in_if #(
  parameter int SW   = 16,
  parameter int CW   = 16,
  parameter int SETW = 1,
  parameter int IDXW = 6
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic signed [SW-1:0]   sample_i;
  logic signed [SW-1:0]   sample_q;
  logic [SETW-1:0]        coef_set;
  logic [IDXW-1:0]        coef_index;
  logic signed [CW-1:0]   coef_value;

  modport source (
    output valid, mode, sample_i, sample_q, coef_set, coef_index, coef_value,
    input  ready
  );
  modport sink (
    input  valid, mode, sample_i, sample_q, coef_set, coef_index, coef_value,
    output ready
  );
endinterface

### rtl/core/sfiq_out_if.sv
// ----------------------------------------------------------------------------
// sfiq_out_if
// Result item channel: filtered I/Q pair.
// ----------------------------------------------------------------------------
interface sfiq_out_if #(
  parameter int SW = 16
);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] filtered_i;
  logic signed [SW-1:0] filtered_q;

  modport source (
    output valid, filtered_i, filtered_q,
    input  ready
  );
  modport sink (
    input  valid, filtered_i, filtered_q,
    output ready
  );
endinterface

### rtl/core/sfiq_ram.sv
// ----------------------------------------------------------------------------
// sfiq_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module sfiq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    ra_addr,
  output logic [WIDTH-1:0] ra_data,
  input  logic [AW-1:0]    rb_addr,
  output logic [WIDTH-1:0] rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

### rtl/core/sfiq_ctrl.sv
// ----------------------------------------------------------------------------
// sfiq_ctrl
// Sequencer: accepts items, walks the tap pairs, drains the MAC pipeline and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module sfiq_ctrl #(
  parameter int TAPS = sfiq_pkg::TAPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  sfiq_pkg::sfiq_stat_t stat,
  output sfiq_pkg::sfiq_cmd_t  cmd
);

  localparam int HALF  = TAPS / 2;
  localparam int CNT_W = $clog2(HALF + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.push    = accept && (in_mode == sfiq_pkg::MODE_SAMPLE);
        cmd.coef_wr = accept && (in_mode == sfiq_pkg::MODE_COEF);
        if (cmd.push) begin
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.issue  = 1'b1;
        cmd.center = (cnt_r == CNT_W'(HALF));
        cnt_nxt    = cnt_r + 1'b1;
        if (cmd.center) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/core/sfiq_dp.sv
// ----------------------------------------------------------------------------
// sfiq_dp
// Datapath: delay line and coefficient memories, pre-add, shared I/Q
// multiply-accumulate, rounding, saturation and output register.
// ----------------------------------------------------------------------------
module sfiq_dp #(
  parameter int TAPS         = sfiq_pkg::TAPS_DEF,
  parameter int COEF_SETS    = sfiq_pkg::COEF_SETS_DEF,
  parameter int SAMPLE_WIDTH = sfiq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sfiq_pkg::COEF_WIDTH_DEF,
  parameter int SET_W        = (COEF_SETS > 1) ? $clog2(COEF_SETS) : 1,
  parameter int IDX_W        = $clog2(TAPS / 2 + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfiq_pkg::sfiq_cmd_t           cmd,
  output sfiq_pkg::sfiq_stat_t          stat,
  input  logic [SET_W-1:0]              profile,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
  input  logic [SET_W-1:0]              coef_set,
  input  logic [IDX_W-1:0]              coef_index,
  input  logic signed [COEF_WIDTH-1:0]  coef_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_q
);

  localparam int SW       = SAMPLE_WIDTH;
  localparam int CW       = COEF_WIDTH;
  localparam int HALF     = TAPS / 2;
  localparam int SET_SIZE = HALF + 1;
  localparam int CDEPTH   = COEF_SETS * SET_SIZE;
  localparam int TAW      = $clog2(TAPS);
  localparam int CAW      = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int PRE_W    = SW + 1;
  localparam int PW       = PRE_W + CW;
  localparam int ACC_W    = PW + IDX_W + 1;
  localparam int RW       = ACC_W + 1 - (CW - 1);
  localparam logic signed [ACC_W:0] RND = (ACC_W + 1)'(1) << (CW - 2);
  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW - 1){1'b0}}};

  // delay line state
  logic [TAW-1:0]  head_r, head_nxt, b_start;
  logic [TAPS-1:0] vld_r;
  logic [TAW-1:0]  ptr_a_r, ptr_b_r;
  logic [2*SW-1:0] da, db;

  // coefficient store
  logic [CAW-1:0]       coef_addr_r, coef_base, coef_waddr;
  logic                 coef_we;
  logic [CW-1:0]        coef_rdata;
  logic [SET_W-1:0]     prof_sel;

  // pipeline
  logic                     s1_v_r, s1_c_r, va_r, vb_r;
  logic                     s2_v_r, s3_v_r;
  logic signed [PRE_W-1:0]  pre_i_nxt, pre_q_nxt, pre_i_r, pre_q_r;
  logic signed [CW-1:0]     coef_r;
  logic signed [PW-1:0]     prod_i_r, prod_q_r;
  logic signed [ACC_W-1:0]  acc_i_r, acc_q_r;
  logic                     out_valid_r;
  logic signed [SW-1:0]     out_i_r, out_q_r, sat_i, sat_q;

  function automatic logic signed [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W:0] shr;
    logic [RW-1:0]         r;
    logic                  fits;
    sum  = $signed({acc[ACC_W-1], acc}) + RND;
    shr  = sum >>> (CW - 1);
    r    = shr[RW-1:0];
    fits = (r[RW-1:SW-1] == '0) || (r[RW-1:SW-1] == '1);
    if (fits) begin
      return $signed(r[SW-1:0]);
    end else if (r[RW-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  assign head_nxt  = (head_r == '0) ? TAW'(TAPS - 1) : head_r - 1'b1;
  assign b_start   = (head_nxt == '0) ? TAW'(TAPS - 1) : head_nxt - 1'b1;
  assign prof_sel  = (int'(profile) < COEF_SETS) ? profile : '0;
  assign coef_base = CAW'(CAW'(prof_sel) * CAW'(SET_SIZE));
  assign coef_waddr = CAW'(CAW'(coef_set) * CAW'(SET_SIZE) + CAW'(coef_index));
  assign coef_we   = cmd.coef_wr && (int'(coef_set) < COEF_SETS)
                     && (int'(coef_index) <= HALF);

  sfiq_ram #(.WIDTH(2 * SW), .DEPTH(TAPS), .AW(TAW)) u_delay (
    .clk     (clk),
    .we      (cmd.push),
    .waddr   (head_nxt),
    .wdata   ({sample_q, sample_i}),
    .ra_addr (ptr_a_r),
    .ra_data (da),
    .rb_addr (ptr_b_r),
    .rb_data (db)
  );

  sfiq_ram #(.WIDTH(CW), .DEPTH(CDEPTH), .AW(CAW)) u_coef (
    .clk     (clk),
    .we      (coef_we),
    .waddr   (coef_waddr),
    .wdata   (coef_value),
    .ra_addr (coef_addr_r),
    .ra_data (coef_rdata),
    .rb_addr ('0),
    .rb_data ()
  );

  // head, valid bits and read pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      vld_r  <= '0;
    end else if (cmd.push) begin
      head_r           <= head_nxt;
      vld_r[head_nxt]  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ptr_a_r     <= head_nxt;
      ptr_b_r     <= b_start;
      coef_addr_r <= coef_base;
    end else if (cmd.issue) begin
      ptr_a_r     <= (ptr_a_r == TAW'(TAPS - 1)) ? '0 : ptr_a_r + 1'b1;
      ptr_b_r     <= (ptr_b_r == '0) ? TAW'(TAPS - 1) : ptr_b_r - 1'b1;
      coef_addr_r <= coef_addr_r + 1'b1;
    end
  end

  // pre-add: unwritten delay entries read as zero, centre tap has no mirror
  always_comb begin
    pre_i_nxt = (va_r ? PRE_W'($signed(da[SW-1:0])) : '0)
              + ((vb_r && !s1_c_r) ? PRE_W'($signed(db[SW-1:0])) : '0);
    pre_q_nxt = (va_r ? PRE_W'($signed(da[2*SW-1:SW])) : '0)
              + ((vb_r && !s1_c_r) ? PRE_W'($signed(db[2*SW-1:SW])) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_c_r   <= cmd.center;
    va_r     <= vld_r[ptr_a_r];
    vb_r     <= vld_r[ptr_b_r];
    pre_i_r  <= pre_i_nxt;
    pre_q_r  <= pre_q_nxt;
    coef_r   <= $signed(coef_rdata);
    prod_i_r <= pre_i_r * coef_r;
    prod_q_r <= pre_q_r * coef_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else if (s3_v_r) begin
      acc_i_r <= acc_i_r + ACC_W'(prod_i_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_q_r);
    end
  end

  assign sat_i = round_sat(acc_i_r);
  assign sat_q = round_sat(acc_q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_i_r <= sat_i;
      out_q_r <= sat_q;
    end
  end

  assign out_valid      = out_valid_r;
  assign filtered_i     = out_i_r;
  assign filtered_q     = out_q_r;
  assign stat.pipe_busy = s1_v_r || s2_v_r || s3_v_r;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

### rtl/core/symmetric_fir_iq.sv
// ----------------------------------------------------------------------------
// symmetric_fir_iq
// Odd-length linear-phase FIR filter for complex I/Q samples with switchable
// coefficient sets.
// ----------------------------------------------------------------------------
// A sample item is written into the delay line at the accepting edge. Then
// the single shared pre-add and I/Q multiply-accumulate unit reads one tap
// pair per cycle (TAPS/2 + 1 reads), the read, pre-add and multiply
// registers drain into the accumulator, the controller sees that pipeline
// empty, and the result is rounded, saturated and loaded into the output
// register. The next item can be taken in the cycle after that, so a new
// sample item is not accepted until the last result is loaded; a result still
// waiting in the output register stalls that load and so holds off the
// following sample. A coefficient item is written at the accepting edge and
// returns no result. The delay line clears at reset through per-entry valid
// bits, so no clearing pass is needed; coefficients must be written before use.
module symmetric_fir_iq #(
  parameter int TAPS         = sfiq_pkg::TAPS_DEF,
  parameter int COEF_SETS    = sfiq_pkg::COEF_SETS_DEF,
  parameter int SAMPLE_WIDTH = sfiq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = sfiq_pkg::COEF_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  sfiq_in_if.sink                      in_item,
  sfiq_out_if.source                   out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfiq_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int SET_W = (COEF_SETS > 1) ? $clog2(COEF_SETS) : 1;
  localparam int IDX_W = $clog2(TAPS / 2 + 1);

  sfiq_pkg::sfiq_cmd_t  cmd;
  sfiq_pkg::sfiq_stat_t stat;
  logic [SET_W-1:0]     profile_r;
  logic                 cfg_wr;
  logic                 sel_profile;

  assign pready      = 1'b1;
  assign cfg_wr      = psel && penable && pwrite && pready;
  assign sel_profile = (paddr[sfiq_pkg::PADDR_W-1:2]
                        == sfiq_pkg::ADDR_PROFILE[sfiq_pkg::PADDR_W-1:2]);
  assign prdata      = sel_profile ? 32'(profile_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profile_r <= '0;
    end else if (cfg_wr && sel_profile) begin
      profile_r <= pwdata[SET_W-1:0];
    end
  end

  sfiq_ctrl #(.TAPS(TAPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_mode  (in_item.mode),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfiq_dp #(
    .TAPS         (TAPS),
    .COEF_SETS    (COEF_SETS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .SET_W        (SET_W),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .profile    (profile_r),
    .sample_i   (in_item.sample_i),
    .sample_q   (in_item.sample_q),
    .coef_set   (in_item.coef_set),
    .coef_index (in_item.coef_index),
    .coef_value (in_item.coef_value),
    .out_ready  (out_item.ready),
    .out_valid  (out_item.valid),
    .filtered_i (out_item.filtered_i),
    .filtered_q (out_item.filtered_q)
  );

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !stat.pipe_busy)
    else $error("result taken before MAC pipeline drained");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_item.valid || out_item.ready))
    else $error("output register overwritten");

  a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> (!in_item.ready && cmd.issue))
    else $error("sample accepted without tap sweep");

endmodule
